FILE: rtl/wdv_pkg.sv
// Shared types, constants and the field compare function for the vertex welding block.
// Used by wdv_ctrl, wdv_datapath and the top level; depends on nothing else.
package wdv_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int COORD_W = 32;
   localparam int TOL_W = 31;
   localparam int IDX_W = 10;
   localparam int TOTAL_W = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_INDEX_W-1:0] REG_USE_TOLERANCE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE = 1'd1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [TOL_W-1:0] tol_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [IDX_W-1:0] vertex_index_type;
   typedef logic [TOTAL_W-1:0] unique_total_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      coord_type tex_u;
      coord_type tex_v;
   } vertex_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic found;
      logic drained;
      logic out_free;
   } dp_status_type;

   function automatic logic field_match(coord_type a, coord_type b, logic use_tol,
                                        tol_type tol);
      logic signed [COORD_W:0] diff;
      logic signed [COORD_W:0] tol_pos;
      logic signed [COORD_W:0] tol_neg;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      tol_pos = $signed({2'b00, tol});
      tol_neg = -tol_pos;
      return (a == b) || (use_tol && (diff < tol_pos) && (diff > tol_neg));
   endfunction

   function automatic logic vertex_match(vertex_type a, vertex_type b, logic use_tol,
                                         tol_type tol);
      return field_match(a.pos_x, b.pos_x, use_tol, tol) &&
             field_match(a.pos_y, b.pos_y, use_tol, tol) &&
             field_match(a.pos_z, b.pos_z, use_tol, tol) &&
             field_match(a.tex_u, b.tex_u, use_tol, tol) &&
             field_match(a.tex_v, b.tex_v, use_tol, tol);
   endfunction

endpackage

FILE: rtl/wdv_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the store of unique vertices.
module wdv_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/wdv_ctrl.sv
// Controller state machine: accepts a vertex, runs the scan, and closes out the beat.
// Depends on wdv_pkg for the command and status structs.
module wdv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wdv_pkg::dp_status_type status,
   output wdv_pkg::ctl_cmd_type   cmd
);
   import wdv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.found || status.drained) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/wdv_datapath.sv
// Datapath: vertex and configuration registers, scan pointer, compare stage,
// vertex store and the result register. Depends on wdv_pkg and wdv_ram.
module wdv_datapath #(
   parameter int MAX_VERTICES = wdv_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wdv_pkg::ctl_cmd_type         cmd,
   output wdv_pkg::dp_status_type       status,
   input  logic                        csr_write_en,
   input  wdv_pkg::csr_index_type       csr_index,
   input  wdv_pkg::csr_data_type        csr_write_data,
   input  logic                        req_mesh_start,
   input  wdv_pkg::coord_type           req_pos_x,
   input  wdv_pkg::coord_type           req_pos_y,
   input  wdv_pkg::coord_type           req_pos_z,
   input  wdv_pkg::coord_type           req_tex_u,
   input  wdv_pkg::coord_type           req_tex_v,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output wdv_pkg::vertex_index_type    rsp_vertex_index,
   output logic                        rsp_is_new,
   output logic                        rsp_table_full,
   output wdv_pkg::unique_total_type    rsp_unique_total
);
   import wdv_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);

   logic             use_tol_ff, use_tol_in;
   tol_type          tol_ff, tol_in;
   vertex_type       item_ff, item_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_addr_ff, scan_addr_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic             found_ff, found_in;
   logic [AW-1:0]    found_idx_ff, found_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   vertex_index_type rsp_index_ff, rsp_index_in;
   logic             rsp_new_ff, rsp_new_in;
   logic             rsp_full_ff, rsp_full_in;
   unique_total_type rsp_total_ff, rsp_total_in;

   logic             issue;
   logic             issue_done;
   logic             mem_wr_en;
   vertex_type       mem_rd_data;
   logic             hit;

   assign issue_done = (scan_addr_ff >= count_ff);
   assign issue = cmd.scan && !issue_done && !found_ff;
   assign hit = rd_valid_ff && vertex_match(item_ff, mem_rd_data, use_tol_ff, tol_ff);
   assign mem_wr_en = cmd.finish && !found_ff && (count_ff < MAX_COUNT);

   wdv_ram #(
      .WIDTH($bits(vertex_type)),
      .DEPTH(MAX_VERTICES)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(item_ff),
      .rd_en  (issue),
      .rd_addr(scan_addr_ff[AW-1:0]),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      use_tol_in = use_tol_ff;
      tol_in = tol_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_USE_TOLERANCE: use_tol_in = csr_write_data[0];
            REG_TOLERANCE: tol_in = csr_write_data[TOL_W-1:0];
            default: begin
               use_tol_in = use_tol_ff;
            end
         endcase
      end
   end

   always_comb begin
      item_in = item_ff;
      count_in = count_ff;
      scan_addr_in = scan_addr_ff;
      rd_valid_in = issue;
      rd_idx_in = scan_addr_ff[AW-1:0];
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_new_in = rsp_new_ff;
      rsp_full_in = rsp_full_ff;
      rsp_total_in = rsp_total_ff;

      if (cmd.start) begin
         item_in.pos_x = req_pos_x;
         item_in.pos_y = req_pos_y;
         item_in.pos_z = req_pos_z;
         item_in.tex_u = req_tex_u;
         item_in.tex_v = req_tex_v;
         if (req_mesh_start) begin
            count_in = '0;
         end
         scan_addr_in = '0;
         rd_valid_in = 1'b0;
         found_in = 1'b0;
      end

      if (issue) begin
         scan_addr_in = scan_addr_ff + CW'(1);
      end

      if (hit && !found_ff) begin
         found_in = 1'b1;
         found_idx_in = rd_idx_ff;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_new_in = 1'b0;
         rsp_full_in = 1'b0;
         if (found_ff) begin
            rsp_index_in = IDX_W'(found_idx_ff);
         end else if (count_ff < MAX_COUNT) begin
            rsp_index_in = IDX_W'(count_ff);
            rsp_new_in = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            rsp_index_in = '0;
            rsp_full_in = 1'b1;
         end
         rsp_total_in = TOTAL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_tol_ff <= 1'b0;
         tol_ff <= '0;
         count_ff <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         use_tol_ff <= use_tol_in;
         tol_ff <= tol_in;
         count_ff <= count_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff <= rd_valid_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rd_idx_ff <= rd_idx_in;
      found_idx_ff <= found_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign status.found = found_ff;
   assign status.drained = issue_done && !rd_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_is_new = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_unique_total = rsp_total_ff;

endmodule

FILE: rtl/weld_duplicate_vertices_top.sv
// Each accepted vertex beat is compared against the unique vertices kept for the current
// mesh, one stored entry per cycle through the read port of the vertex store, lowest index
// first, and the scan stops at the first match. The result sits in an output register, so
// the next beat is accepted while a result still waits to be taken. The store needs no
// clearing after reset.
// Top level: joins wdv_ctrl and wdv_datapath; depends on wdv_pkg.
module weld_duplicate_vertices_top #(
   parameter int MAX_VERTICES = wdv_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  wdv_pkg::csr_index_type    csr_index,
   input  wdv_pkg::csr_data_type     csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mesh_start,
   input  wdv_pkg::coord_type        req_pos_x,
   input  wdv_pkg::coord_type        req_pos_y,
   input  wdv_pkg::coord_type        req_pos_z,
   input  wdv_pkg::coord_type        req_tex_u,
   input  wdv_pkg::coord_type        req_tex_v,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output wdv_pkg::vertex_index_type rsp_vertex_index,
   output logic                     rsp_is_new,
   output logic                     rsp_table_full,
   output wdv_pkg::unique_total_type rsp_unique_total
);
   import wdv_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   wdv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   wdv_datapath #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_mesh_start  (req_mesh_start),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_tex_u       (req_tex_u),
      .req_tex_v       (req_tex_v),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_is_new      (rsp_is_new),
      .rsp_table_full  (rsp_table_full),
      .rsp_unique_total(rsp_unique_total)
   );

endmodule
